// ----- hdl/stbs_pkg.sv -----
`timescale 1ns / 1ps

package stbs_pkg;

	localparam int DEPTH = 128;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int KEY_W = 32;
	localparam int POS_W = 7;
	localparam int PRB_W = 4;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_SEARCH = 1'b1
	} req_type_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_LAST,
		ST_SRCH_ISSUE,
		ST_SRCH_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic [PRB_W-1:0] probes;
		logic             status;
	} res_t;

	// result handshake between the engine and the output register
	typedef struct packed {
		logic valid;
		res_t res;
	} res_chan_t;

endpackage

// ----- hdl/stbs_if.sv -----
`timescale 1ns / 1ps

interface stbs_req_if import stbs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic signed [KEY_W-1:0] key;

	modport source (output valid, output req_type, output key, input ready);
	modport sink (input valid, input req_type, input key, output ready);
endinterface

interface stbs_rsp_if import stbs_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [POS_W-1:0] position;
	logic [PRB_W-1:0] probes;
	logic             status;

	modport source (output valid, output found, output position, output probes,
		output status, input ready);
	modport sink (input valid, input found, input position, input probes,
		input status, output ready);
endinterface

// ----- hdl/stbs_engine.sv -----
`timescale 1ns / 1ps

module stbs_engine import stbs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic                    req_type,
	input  logic signed [KEY_W-1:0] req_key,
	output res_chan_t               res_out,
	input  logic                    res_ready
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        idx_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        lo_q, hix_q;
	logic [IDX_W-1:0]        mid_q;
	logic [PRB_W-1:0]        prb_q;
	res_t                    res_q;

	logic signed [KEY_W-1:0] mem [DEPTH];
	logic signed [KEY_W-1:0] rd_q;
	logic                    mem_we;
	logic [IDX_W-1:0]        mem_wa, mem_ra;
	logic signed [KEY_W-1:0] mem_wd;

	logic             accept;
	logic             key_less;
	logic             key_hit;
	logic             cnt_full, cnt_empty;
	logic             win_open;
	logic [CNT_W:0]   mid_sum;
	logic [IDX_W-1:0] mid;

	assign accept    = req_valid && req_ready;
	assign key_less  = key_q < rd_q;
	assign key_hit   = key_q == rd_q;
	assign cnt_full  = cnt_q == CNT_W'(DEPTH);
	assign cnt_empty = cnt_q == '0;
	assign win_open  = lo_q < hix_q;
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hix_q} - {{CNT_W{1'b0}}, 1'b1};
	assign mid       = IDX_W'(mid_sum[CNT_W:1]);

	// key table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_SEARCH) begin
						state_d = ST_SRCH_ISSUE;
					end else if (cnt_full || cnt_empty) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_INS_CMP;
					end
				end
			end
			ST_INS_CMP: begin
				if (!key_less) begin
					state_d = ST_DONE;
				end else if (idx_q == IDX_W'(1)) begin
					state_d = ST_INS_LAST;
				end
			end
			ST_INS_LAST:   state_d = ST_DONE;
			ST_SRCH_ISSUE: state_d = win_open ? ST_SRCH_CMP : ST_DONE;
			ST_SRCH_CMP:   state_d = key_hit ? ST_DONE : ST_SRCH_ISSUE;
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready     = state_q == ST_IDLE;
		res_out.valid = state_q == ST_DONE;
		res_out.res   = res_q;
		mem_we        = 1'b0;
		mem_wa        = idx_q;
		mem_wd        = key_q;
		mem_ra        = '0;
		case (state_q)
			ST_IDLE: begin
				mem_wa = '0;
				mem_wd = req_key;
				mem_ra = IDX_W'(cnt_q - CNT_W'(1));
				mem_we = accept && req_type == REQ_INSERT && cnt_empty;
			end
			ST_INS_CMP: begin
				mem_we = 1'b1;
				mem_wd = key_less ? rd_q : key_q;
				mem_ra = idx_q - IDX_W'(2);
			end
			ST_INS_LAST: begin
				mem_we = 1'b1;
				mem_wa = '0;
			end
			ST_SRCH_ISSUE: mem_ra = mid;
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_IDLE && accept && req_type == REQ_INSERT && cnt_empty)
				|| (state_q == ST_INS_CMP && !key_less) || state_q == ST_INS_LAST) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q <= req_key;
				idx_q <= IDX_W'(cnt_q);
				lo_q  <= '0;
				hix_q <= cnt_q;
				prb_q <= '0;
				res_q <= '{found: 1'b0, position: '0, probes: '0,
					status: req_type == REQ_INSERT && cnt_full};
			end
			ST_INS_CMP: begin
				if (key_less) begin
					idx_q <= idx_q - IDX_W'(1);
				end
			end
			ST_SRCH_ISSUE: begin
				if (win_open) begin
					mid_q <= mid;
					prb_q <= prb_q + PRB_W'(1);
				end else begin
					res_q.probes <= prb_q;
				end
			end
			ST_SRCH_CMP: begin
				if (key_hit) begin
					res_q.found    <= 1'b1;
					res_q.position <= POS_W'(mid_q);
					res_q.probes   <= prb_q;
				end else if (key_less) begin
					hix_q <= CNT_W'(mid_q);
				end else begin
					lo_q <= CNT_W'(mid_q) + CNT_W'(1);
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

endmodule

// ----- hdl/sorted_table_binary_search.sv -----
`timescale 1ns / 1ps
// Sorted table of signed keys with binary search, one request at a time.
// Insert: each shift step moves one entry up a place (one table port pair).
// Search: each probe is a registered table read, then a compare; at most 8 probes.
// A finished result sits in an output register, so the next request is taken meanwhile.
// Reset clears the entry count and control state; the key table itself is not cleared.

module sorted_table_binary_search import stbs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	stbs_req_if.sink   req,
	stbs_rsp_if.source rsp
);

	res_chan_t core_res;
	logic      core_res_ready;
	logic      out_valid_q;
	res_t      out_res_q;

	// Engine: FSM around the key table. Inserts walk down from the top
	// filled entry, moving larger keys up by one; searches halve the
	// window [lo, hi) with the lower midpoint.
	stbs_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_type  (req.req_type),
		.req_key   (req.key),
		.res_out   (core_res),
		.res_ready (core_res_ready)
	);

	// Output register: take a new result when empty or being drained.
	assign core_res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_res_ready) begin
			out_valid_q <= core_res.valid;
		end
	end

	// Hold the payload while the result waits.
	always_ff @(posedge clk) begin
		if (core_res_ready && core_res.valid) begin
			out_res_q <= core_res.res;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.found    = out_res_q.found;
	assign rsp.position = out_res_q.position;
	assign rsp.probes   = out_res_q.probes;
	assign rsp.status   = out_res_q.status;

	// One request in flight: the engine drops ready right after taking one.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("engine took a request while busy");

	// A result handed over by the engine shows up at the output next cycle.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		core_res.valid && core_res_ready |=> rsp.valid)
		else $error("result lost in output register");

	// A refused insert carries no search outcome.
	a_refused_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> !rsp.found && rsp.probes == '0 && rsp.position == '0)
		else $error("refused insert carries search fields");

endmodule
